// ----- hdl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the scope frame packer
// Frame word layout, CRC-16 constants and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int FIELD_COUNT = 4;
	localparam int BYTE_COUNT = 2 * FIELD_COUNT;
	localparam int BYTE_SEL_W = $clog2(BYTE_COUNT);
	localparam int IDX_W = $clog2(BYTE_COUNT + 2);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef logic [BYTE_COUNT-1:0][7:0] frame_t;

	typedef struct packed {
		logic   valid;
		frame_t data;
	} frame_head_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- hdl/sfc_front.sv -----
// ----------------------------------------------------------------------------
// sfc_front: frame request queue
// Accepts channel sets and holds them in a two-entry queue for the serializer.
// ----------------------------------------------------------------------------
module sfc_front
	import sfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  frame_t      frame_in,
	output frame_head_t head,
	input  logic        head_pop
);

	frame_t      entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = head_pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= frame_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/sfc_back.sv -----
// ----------------------------------------------------------------------------
// sfc_back: frame serializer
// Sends the queued frame one byte per cycle while pop is high, folds each data
// byte into the CRC-16, appends the CRC low byte first, flags the last byte.
// ----------------------------------------------------------------------------
module sfc_back
	import sfc_pkg::*;
#(
	parameter int CHANNEL_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_head_t head,
	output logic        head_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);

	localparam int USED = (CHANNEL_COUNT < 1) ? 1 :
		((CHANNEL_COUNT > FIELD_COUNT) ? FIELD_COUNT : CHANNEL_COUNT);
	localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(2 * USED);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * USED + 1);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             end_q;
	logic             advance;
	logic             is_data;
	logic             is_last;
	logic [7:0]       data_byte;
	logic [7:0]       next_byte;

	assign advance   = !out_valid_q || pop;
	assign is_data   = (idx_q < CRC_LO_IDX);
	assign is_last   = (idx_q == LAST_IDX);
	assign data_byte = head.data[idx_q[BYTE_SEL_W-1:0]];
	assign next_byte = is_data ? data_byte :
		((idx_q == CRC_LO_IDX) ? crc_q[7:0] : crc_q[15:8]);
	assign head_pop  = advance && head.valid && is_last;

	assign empty      = !out_valid_q;
	assign frame_byte = byte_q;
	assign frame_end  = end_q;

	always_ff @(posedge clk) begin
		if (advance && head.valid) begin
			byte_q <= next_byte;
			end_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				if (is_last) begin
					idx_q <= '0;
					crc_q <= CRC_INIT;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
					if (is_data) begin
						crc_q <= crc_byte(crc_q, data_byte);
					end
				end
			end
		end
	end

endmodule

// ----- hdl/scope_frame_crc16_packer.sv -----
// ----------------------------------------------------------------------------
// scope_frame_crc16_packer: serial scope frame builder with CRC-16/MODBUS
// Packs the channel values of one request into a byte frame with its CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the four channel values with push; a request
//   is taken on a clock edge with push high and full low. Up to two requests
//   wait in the front queue.
//   Output side is a queue: while empty is low, frame_byte and frame_end show
//   the oldest byte; pop takes it. A frame is 2*CHANNEL_COUNT+2 bytes, with
//   CHANNEL_COUNT clamped to 1..4 (ten at the default): the channels low
//   byte first, then CRC low, CRC high. frame_end marks the last byte.
//   The first byte passes through the front queue and then the output
//   register before empty goes low. Bytes leave one per cycle through the
//   single output register while pop stays high and a request is queued.
//   When pop is low the output byte holds and the serializer waits; the front
//   queue still takes requests until full.
//   Reset clears both queues and the CRC; no frame is in flight afterwards.
// ----------------------------------------------------------------------------
module scope_frame_crc16_packer
	import sfc_pkg::*;
#(
	parameter int CHANNEL_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] channel_zero,
	input  logic [15:0] channel_one,
	input  logic [15:0] channel_two,
	input  logic [15:0] channel_three,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);

	frame_t      frame_in;
	frame_head_t head;
	logic        head_pop;

	assign frame_in = {channel_three, channel_two, channel_one, channel_zero};

	sfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.frame_in (frame_in),
		.head     (head),
		.head_pop (head_pop)
	);

	sfc_back #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule

// ----- hdl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// sfc_checker: port-level checks of the scope frame packer
// Watches both queue interfaces and is bound to the top level.
// ----------------------------------------------------------------------------
module sfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] frame_byte,
	input logic       frame_end
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_end)))
		else $error("stalled output byte changed");

	a_no_double_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && frame_end) |=> !(!empty && frame_end))
		else $error("two frame ends in a row");

	a_full_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue became full without a request");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |=> ##1 !empty)
		else $error("first byte of idle frame late");

endmodule

bind scope_frame_crc16_packer sfc_checker u_sfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.frame_byte (frame_byte),
	.frame_end  (frame_end)
);
